@@ src/epmf_pkg.sv @@
// shared types and constants for the encoder period median filter
package epmf_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned CountW        = 16;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned WindowDefault = 10;

  typedef logic [DataW-1:0]  data_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [CmdW-1:0]   cmd_t;

  localparam data_t  PresetDefault = data_t'(1832);
  localparam count_t CountMax      = '1;

  // request codes
  localparam cmd_t CmdTick  = cmd_t'(0);
  localparam cmd_t CmdReset = cmd_t'(1);
  localparam cmd_t CmdInit  = cmd_t'(2);

  // per-cycle control sent from the sequencer to every cell
  typedef struct packed {
    logic win_shift;
    logic win_fill;
    logic rank_init;
    logic rank_step;
  } cell_ctl_t;

endpackage

@@ src/encoder_period_median_filter.sv @@
// top level of the encoder period median filter
//
// each request (tick, reset or init) returns one result carrying the
// saturating tick count, the newest interval and the upper median of the
// last WINDOW intervals. the window lives in a ring of WINDOW cells; after
// the window is updated each cell takes a copy of its neighbor's entry as a
// probe, and the probes rotate round the ring past every other cell while
// each cell counts how many probes sort below its own entry (ties broken
// by slot). the cell whose rank is WINDOW/2 supplies the median. a request
// is taken in the idle state, where the window is updated; the init state
// seeds the probes, the rank state rotates them, and the output state loads
// the output register. the output register lets a new request enter while
// a result still waits to be taken; the block only holds in its output
// state if the previous result is still pending. the preset interval
// register may be written at any time the block is idle and takes effect
// on the next reset or init request.
module encoder_period_median_filter #(
  parameter int unsigned WINDOW = epmf_pkg::WindowDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // preset interval register
  input  logic                   cfg_we_i,
  input  epmf_pkg::data_t        cfg_wdata_i,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  epmf_pkg::cmd_t         cmd_i,
  input  epmf_pkg::data_t        time_us_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output epmf_pkg::count_t       tick_count_o,
  output epmf_pkg::data_t        last_interval_o,
  output epmf_pkg::data_t        median_interval_o
);

  localparam int unsigned IdxW    = $clog2(WINDOW);
  localparam int unsigned MedRank = WINDOW / 2;

  // sequencer states
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StInit = 2'd1;
  localparam logic [1:0] StRank = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IdxW-1:0]  step_q, step_d;
  epmf_pkg::data_t  preset_q;
  epmf_pkg::data_t  prev_time_q;
  epmf_pkg::count_t tick_cnt_q;

  logic             out_valid_q;
  epmf_pkg::count_t out_count_q;
  epmf_pkg::data_t  out_last_q, out_med_q;

  logic                accept;
  logic                is_tick, is_fill;
  logic                out_load;
  epmf_pkg::data_t     interval;
  epmf_pkg::data_t     median;
  epmf_pkg::cell_ctl_t ctl;

  epmf_pkg::data_t entry_w [WINDOW];
  epmf_pkg::data_t probe_w [WINDOW];
  logic [IdxW-1:0] pidx_w  [WINDOW];
  logic [IdxW-1:0] rank_w  [WINDOW];

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign is_tick    = (cmd_i == epmf_pkg::CmdTick);
  assign is_fill    = (cmd_i == epmf_pkg::CmdReset) || (cmd_i == epmf_pkg::CmdInit);
  // wraparound difference gives the right interval across a timer rollover
  assign interval   = time_us_i - prev_time_q;
  assign out_load   = (state_q == StOut) && (!out_valid_q || out_ready_i);

  assign ctl.win_shift = accept && is_tick;
  assign ctl.win_fill  = accept && is_fill;
  assign ctl.rank_init = (state_q == StInit);
  assign ctl.rank_step = (state_q == StRank);

  // ring of cells: entries shift toward slot 0 (oldest), probes rotate upward
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    localparam int unsigned Prv = (k + WINDOW - 1) % WINDOW;
    epmf_pkg::data_t shift_in;

    if (k == WINDOW - 1) begin : g_newest
      assign shift_in = interval;
    end else begin : g_older
      assign shift_in = entry_w[k+1];
    end

    epmf_cell #(
      .Window  (WINDOW),
      .CellIdx (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .preset_i    (preset_q),
      .shift_in_i  (shift_in),
      .nbr_entry_i (entry_w[Prv]),
      .nbr_probe_i (probe_w[Prv]),
      .nbr_pidx_i  (pidx_w[Prv]),
      .entry_o     (entry_w[k]),
      .probe_o     (probe_w[k]),
      .pidx_o      (pidx_w[k]),
      .rank_o      (rank_w[k])
    );
  end

  // ranks form a permutation, so exactly one cell matches the median rank
  always_comb begin
    median = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (rank_w[k] == IdxW'(MedRank)) begin
        median = median | entry_w[k];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StInit;
        end
      end
      StInit: begin
        step_d  = '0;
        state_d = StRank;
      end
      StRank: begin
        step_d = step_q + IdxW'(1);
        if (step_q == IdxW'(WINDOW - 2)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // preset register, time stamp and tick counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q    <= epmf_pkg::PresetDefault;
      prev_time_q <= '0;
      tick_cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        preset_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (is_tick) begin
          prev_time_q <= time_us_i;
          if (tick_cnt_q != epmf_pkg::CountMax) begin
            tick_cnt_q <= tick_cnt_q + epmf_pkg::count_t'(1);
          end
        end else if (is_fill) begin
          tick_cnt_q <= '0;
          if (cmd_i == epmf_pkg::CmdInit) begin
            prev_time_q <= time_us_i;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= tick_cnt_q;
      out_last_q  <= entry_w[WINDOW-1];
      out_med_q   <= median;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign tick_count_o      = out_count_q;
  assign last_interval_o   = out_last_q;
  assign median_interval_o = out_med_q;

endmodule

@@ src/epmf_cell.sv @@
// one window cell: holds an entry and ranks it against a circulating probe
module epmf_cell #(
  parameter int unsigned Window  = epmf_pkg::WindowDefault,
  parameter int unsigned CellIdx = 0,
  localparam int unsigned IdxW   = $clog2(Window)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  epmf_pkg::cell_ctl_t ctl_i,
  input  epmf_pkg::data_t     preset_i,
  input  epmf_pkg::data_t     shift_in_i,
  input  epmf_pkg::data_t     nbr_entry_i,
  input  epmf_pkg::data_t     nbr_probe_i,
  input  logic [IdxW-1:0]     nbr_pidx_i,
  output epmf_pkg::data_t     entry_o,
  output epmf_pkg::data_t     probe_o,
  output logic [IdxW-1:0]     pidx_o,
  output logic [IdxW-1:0]     rank_o
);

  localparam int unsigned InitIdx = (CellIdx + Window - 1) % Window;

  epmf_pkg::data_t entry_q, probe_q;
  logic [IdxW-1:0] pidx_q, rank_q;
  logic            inc;

  // probe sorts before this entry: smaller, or equal and from a lower slot
  assign inc = (probe_q < entry_q) ||
               ((probe_q == entry_q) && (pidx_q < IdxW'(CellIdx)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= epmf_pkg::PresetDefault;
    end else if (ctl_i.win_fill) begin
      entry_q <= preset_i;
    end else if (ctl_i.win_shift) begin
      entry_q <= shift_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rank_init) begin
      probe_q <= nbr_entry_i;
      pidx_q  <= IdxW'(InitIdx);
      rank_q  <= '0;
    end else if (ctl_i.rank_step) begin
      probe_q <= nbr_probe_i;
      pidx_q  <= nbr_pidx_i;
      rank_q  <= rank_q + IdxW'(inc);
    end
  end

  assign entry_o = entry_q;
  assign probe_o = probe_q;
  assign pidx_o  = pidx_q;
  assign rank_o  = rank_q;

endmodule

@@ src/epmf_checker.sv @@
// port-level checks for the encoder period median filter, bound to the top
module epmf_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input epmf_pkg::count_t       tick_count_o,
  input epmf_pkg::data_t        last_interval_o,
  input epmf_pkg::data_t        median_interval_o
);

  // one request at a time: taking a request closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after taking a request");

  // a result passes through the sequencer states first, so none appears right after a request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result showed up one cycle after its request");

  // a stalled result keeps its payload
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tick_count_o) &&
      $stable(last_interval_o) && $stable(median_interval_o))
    else $error("stalled result dropped or changed");

endmodule

bind encoder_period_median_filter epmf_checker u_epmf_checker (.*);
